[rtl/core/lrg_pkg.sv]
// ----------------------------------------------------------------------------
// lrg_pkg
// Shared types and constants of the lagged random generator: field widths,
// the table modulus, the lag distance and the item function codes.
// ----------------------------------------------------------------------------
package lrg_pkg;

    // Field widths of the input and result transactions
    localparam int FUNC_W  = 2;
    localparam int SLOT_W  = 7;
    localparam int VALUE_W = 30;
    localparam int FRAC_W  = 25;

    // Lagged table recursion
    localparam logic [VALUE_W-1:0] LAG_MOD      = 30'd1000009711;
    localparam int                 LAG_DISTANCE = 64;

    // Sum 2*lag + 5*cur stays below 7*M, so it fits in 33 bits
    localparam int SUM_W   = 33;
    localparam int MAX_MUL = 6;

    // Second generator multiplier
    localparam logic [FRAC_W-1:0] FRAC_MULT = 25'd37;

    // Item function codes
    typedef enum logic [FUNC_W-1:0] {
        FUNC_LOAD_ENTRY = 2'd0,
        FUNC_LOAD_SEED  = 2'd1,
        FUNC_GENERATE   = 2'd2
    } t_func;

endpackage

[rtl/core/lrg_in_if.sv]
// ----------------------------------------------------------------------------
// lrg_in_if
// Input channel: valid/ready handshake carrying one item (func, slot, value).
// ----------------------------------------------------------------------------
interface lrg_in_if;
    logic                          valid;
    logic                          ready;
    logic [lrg_pkg::FUNC_W-1:0]    func;
    logic [lrg_pkg::SLOT_W-1:0]    slot;
    logic [lrg_pkg::VALUE_W-1:0]   value;

    modport source (output valid, output func, output slot, output value, input ready);
    modport sink   (input valid, input func, input slot, input value, output ready);
endinterface

[rtl/core/lrg_out_if.sv]
// ----------------------------------------------------------------------------
// lrg_out_if
// Result channel: valid/ready handshake carrying one generated pair.
// ----------------------------------------------------------------------------
interface lrg_out_if;
    logic                          valid;
    logic                          ready;
    logic [lrg_pkg::VALUE_W-1:0]   lagged_value;
    logic [lrg_pkg::FRAC_W-1:0]    fraction_numer;

    modport source (output valid, output lagged_value, output fraction_numer, input ready);
    modport sink   (input valid, input lagged_value, input fraction_numer, output ready);
endinterface

[rtl/core/lrg_ram.sv]
// ----------------------------------------------------------------------------
// lrg_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data (old data on a same-address read during write).
// ----------------------------------------------------------------------------
module lrg_ram #(
    parameter int WIDTH = 30,
    parameter int DEPTH = 101
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/lrg_table.sv]
// ----------------------------------------------------------------------------
// lrg_table
// Lag table storage: two RAM copies written together give the current and
// the lagged entry from one read. A write in the same cycle as a read of the
// same entry is forwarded to the read data.
// ----------------------------------------------------------------------------
module lrg_table #(
    parameter int TABLE_LENGTH = 101,
    parameter int ADDR_W       = $clog2(TABLE_LENGTH)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_re,
    input  logic [ADDR_W-1:0]             i_addr_cur,
    input  logic [ADDR_W-1:0]             i_addr_lag,
    input  logic                          i_we,
    input  logic [ADDR_W-1:0]             i_waddr,
    input  logic [lrg_pkg::VALUE_W-1:0]   i_wdata,
    output logic [lrg_pkg::VALUE_W-1:0]   o_cur,
    output logic [lrg_pkg::VALUE_W-1:0]   o_lag
);

    logic [lrg_pkg::VALUE_W-1:0] q_cur;
    logic [lrg_pkg::VALUE_W-1:0] q_lag;
    logic                        r_fwd_cur;
    logic                        r_fwd_lag;
    logic [lrg_pkg::VALUE_W-1:0] r_fwd_data;

    lrg_ram #(
        .WIDTH (lrg_pkg::VALUE_W),
        .DEPTH (TABLE_LENGTH)
    ) u_ram_cur (
        .i_clk   (i_clk),
        .i_we    (i_we),
        .i_waddr (i_waddr),
        .i_wdata (i_wdata),
        .i_re    (i_re),
        .i_raddr (i_addr_cur),
        .o_rdata (q_cur)
    );

    lrg_ram #(
        .WIDTH (lrg_pkg::VALUE_W),
        .DEPTH (TABLE_LENGTH)
    ) u_ram_lag (
        .i_clk   (i_clk),
        .i_we    (i_we),
        .i_waddr (i_waddr),
        .i_wdata (i_wdata),
        .i_re    (i_re),
        .i_raddr (i_addr_lag),
        .o_rdata (q_lag)
    );

    // Capture a write that collides with the read being issued
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_cur <= 1'b0;
            r_fwd_lag <= 1'b0;
        end else if (i_re) begin
            r_fwd_cur <= i_we && (i_waddr == i_addr_cur);
            r_fwd_lag <= i_we && (i_waddr == i_addr_lag);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_fwd_data <= i_wdata;
        end
    end

    assign o_cur = r_fwd_cur ? r_fwd_data : q_cur;
    assign o_lag = r_fwd_lag ? r_fwd_data : q_lag;

endmodule

[rtl/core/lrg_lag_mod.sv]
// ----------------------------------------------------------------------------
// lrg_lag_mod
// Table recursion: fresh = (-(2*lag + 5*cur)) mod M. The sum is below 7*M,
// so the remainder comes from six parallel compares and one subtract.
// ----------------------------------------------------------------------------
module lrg_lag_mod (
    input  logic [lrg_pkg::VALUE_W-1:0] i_cur,
    input  logic [lrg_pkg::VALUE_W-1:0] i_lag,
    output logic [lrg_pkg::VALUE_W-1:0] o_fresh
);

    logic [lrg_pkg::SUM_W-1:0] sum;
    logic [lrg_pkg::SUM_W-1:0] rem;
    logic [lrg_pkg::SUM_W-1:0] negated;

    // 2*lag + 4*cur + cur
    assign sum = {2'b00, i_lag, 1'b0}
               + {1'b0, i_cur, 2'b00}
               + {3'b000, i_cur};

    // Subtract the largest multiple of M not above the sum
    always_comb begin
        rem = sum;
        for (int k = 1; k <= lrg_pkg::MAX_MUL; k++) begin
            if (sum >= lrg_pkg::SUM_W'(k) * lrg_pkg::SUM_W'(lrg_pkg::LAG_MOD)) begin
                rem = sum - lrg_pkg::SUM_W'(k) * lrg_pkg::SUM_W'(lrg_pkg::LAG_MOD);
            end
        end
    end

    // Negate modulo M; zero stays zero
    assign negated = lrg_pkg::SUM_W'(lrg_pkg::LAG_MOD) - rem;
    assign o_fresh = (rem == '0) ? '0 : negated[lrg_pkg::VALUE_W-1:0];

endmodule

[rtl/core/lagged_random_generator.sv]
// ----------------------------------------------------------------------------
// lagged_random_generator
// Combined uniform random generator: a lagged table recursion modulo
// 1000009711 over a table in block RAM, plus a 25-bit congruential stage.
//
// Usage:
//   i_in is the item channel. func selects a table load (slot, value), a
//   second-state load (value, also sets the position to zero) or a generate.
//   Load every table entry before the first generate.
//   o_out returns one transaction per generate: the new table entry and the
//   new second-state numerator. Loads and unused codes return nothing.
//   A generate result passes the update stage, then the output register.
//   Throughput: one item per cycle while i_in.ready is high. The table read
//   is issued at acceptance; the recursion and the write-back happen in the
//   update stage, and a same-cycle write to an entry being read is forwarded.
//   Reset clears the position, the second state and all valid flags; the
//   table contents are undefined until loaded.
//   When the receiver stalls, one result waits in the output register and
//   one more in the update stage; after that i_in.ready drops.
// ----------------------------------------------------------------------------
module lagged_random_generator #(
    parameter int TABLE_LENGTH = 101
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    lrg_in_if.sink           i_in,
    lrg_out_if.source        o_out
);

    localparam int ADDR_W = $clog2(TABLE_LENGTH);

    // Front end state
    logic [ADDR_W-1:0]               r_position;
    logic [ADDR_W-1:0]               n_position;
    logic [lrg_pkg::FRAC_W-1:0]      r_state;
    logic [lrg_pkg::FRAC_W-1:0]      n_state;

    // Update stage
    logic                            r_s1_valid;
    logic                            r_s1_gen;
    logic [ADDR_W-1:0]               r_s1_addr;
    logic [lrg_pkg::VALUE_W-1:0]     r_s1_load;
    logic [lrg_pkg::FRAC_W-1:0]      r_s1_frac;

    // Output register
    logic                            r_out_valid;
    logic [lrg_pkg::VALUE_W-1:0]     r_out_lagged;
    logic [lrg_pkg::FRAC_W-1:0]      r_out_frac;

    logic                            accept;
    logic                            is_load;
    logic                            is_seed;
    logic                            is_gen;
    logic                            slot_ok;
    logic                            s1_advance;
    logic [ADDR_W-1:0]               addr_lag;
    logic [ADDR_W-1:0]               pos_next;
    logic [lrg_pkg::FRAC_W-1:0]      frac_step;
    logic [lrg_pkg::FRAC_W-1:0]      frac_next;
    logic [lrg_pkg::VALUE_W-1:0]     load_value;
    logic [lrg_pkg::VALUE_W-1:0]     tbl_cur;
    logic [lrg_pkg::VALUE_W-1:0]     tbl_lag;
    logic [lrg_pkg::VALUE_W-1:0]     fresh;
    logic                            tbl_we;
    logic [lrg_pkg::VALUE_W-1:0]     tbl_wdata;

    // Function decode
    always_comb begin
        is_load = 1'b0;
        is_seed = 1'b0;
        is_gen  = 1'b0;
        case (lrg_pkg::t_func'(i_in.func))
            lrg_pkg::FUNC_LOAD_ENTRY: is_load = 1'b1;
            lrg_pkg::FUNC_LOAD_SEED:  is_seed = 1'b1;
            lrg_pkg::FUNC_GENERATE:   is_gen  = 1'b1;
            default: ;
        endcase
    end

    // Handshake: the update stage moves on unless a result has nowhere to go
    assign s1_advance = r_s1_valid && (!r_s1_gen || !r_out_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || s1_advance;
    assign accept     = i_in.valid && i_in.ready;

    assign slot_ok = (32'(i_in.slot) < TABLE_LENGTH);

    // Read addresses and position wrap
    assign addr_lag = (r_position >= ADDR_W'(lrg_pkg::LAG_DISTANCE))
                    ? r_position - ADDR_W'(lrg_pkg::LAG_DISTANCE)
                    : r_position + ADDR_W'(TABLE_LENGTH - lrg_pkg::LAG_DISTANCE);
    assign pos_next = (r_position == ADDR_W'(TABLE_LENGTH - 1))
                    ? '0 : r_position + 1'b1;

    // Second generator: k = 37k + 1 mod 2^25, a zero steps once more to one
    assign frac_step = r_state * lrg_pkg::FRAC_MULT + 1'b1;
    assign frac_next = (frac_step == '0) ? lrg_pkg::FRAC_W'(1) : frac_step;

    // Loaded entries are reduced below M
    assign load_value = (i_in.value >= lrg_pkg::LAG_MOD)
                      ? i_in.value - lrg_pkg::LAG_MOD : i_in.value;

    // Front end state update
    always_comb begin
        n_position = r_position;
        n_state    = r_state;
        if (accept && is_gen) begin
            n_position = pos_next;
            n_state    = frac_next;
        end else if (accept && is_seed) begin
            n_position = '0;
            n_state    = i_in.value[lrg_pkg::FRAC_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_position <= '0;
            r_state    <= '0;
        end else begin
            r_position <= n_position;
            r_state    <= n_state;
        end
    end

    // Update stage registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= accept && (is_gen || (is_load && slot_ok));
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_gen  <= is_gen;
            r_s1_addr <= is_gen ? r_position : ADDR_W'(i_in.slot);
            r_s1_load <= load_value;
            r_s1_frac <= frac_next;
        end
    end

    // Table with forwarding
    lrg_table #(
        .TABLE_LENGTH (TABLE_LENGTH),
        .ADDR_W       (ADDR_W)
    ) u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_re       (accept && is_gen),
        .i_addr_cur (r_position),
        .i_addr_lag (addr_lag),
        .i_we       (tbl_we),
        .i_waddr    (r_s1_addr),
        .i_wdata    (tbl_wdata),
        .o_cur      (tbl_cur),
        .o_lag      (tbl_lag)
    );

    // Recursion
    lrg_lag_mod u_lag_mod (
        .i_cur   (tbl_cur),
        .i_lag   (tbl_lag),
        .o_fresh (fresh)
    );

    // Write-back once, when the update stage moves on
    assign tbl_we    = s1_advance;
    assign tbl_wdata = r_s1_gen ? fresh : r_s1_load;

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_advance && r_s1_gen) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_advance && r_s1_gen) begin
            r_out_lagged <= fresh;
            r_out_frac   <= r_s1_frac;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.lagged_value   = r_out_lagged;
    assign o_out.fraction_numer = r_out_frac;

endmodule

[tb/sv/lrg_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrg_checker
// Watches the item and result channels of the lagged random generator. It
// keeps its own copy of the lag table, the table position and the 25-bit
// second state, predicts one pair per accepted generate transaction and
// compares each accepted result with the oldest pending prediction.
// ----------------------------------------------------------------------------
module lrg_checker
    import lrg_pkg::*;
#(
    parameter int TABLE_LENGTH = 101
) (
    input  logic i_clk,
    input  logic i_rst_n,
    lrg_in_if    i_in,
    lrg_out_if   i_out,
    output int   o_mismatches,
    output int   o_outstanding
);

    typedef struct packed {
        logic [VALUE_W-1:0] lagged_value;
        logic [FRAC_W-1:0]  fraction_numer;
    } t_gen_pair;

    logic [VALUE_W-1:0] lag_table [TABLE_LENGTH];
    int unsigned        table_pos;
    logic [FRAC_W-1:0]  frac_state;
    t_gen_pair          pending_pairs [$];
    int                 mismatch_count = 0;

    // One step of the 25-bit congruential stage (wraps mod 2^25)
    function automatic logic [FRAC_W-1:0] next_fraction(input logic [FRAC_W-1:0] k);
        return FRAC_MULT * k + 25'd1;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: %s mismatch: got %0d, expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    // Update the predicted state with one accepted item transaction
    task automatic apply_item(input logic [FUNC_W-1:0] func,
                              input logic [SLOT_W-1:0] slot,
                              input logic [VALUE_W-1:0] value);
        int unsigned        cur_idx;
        int unsigned        lag_idx;
        logic [63:0]        sum;
        logic [63:0]        rem;
        logic [VALUE_W-1:0] fresh;
        case (t_func'(func))
            FUNC_LOAD_ENTRY: begin
                // Out-of-range slots are dropped; values >= M are reduced once
                if (slot < TABLE_LENGTH)
                    lag_table[slot] = (value >= LAG_MOD) ? value - LAG_MOD : value;
            end
            FUNC_LOAD_SEED: begin
                frac_state = value[FRAC_W-1:0];
                table_pos  = 0;
            end
            FUNC_GENERATE: begin
                cur_idx = (table_pos >= TABLE_LENGTH) ? 0 : table_pos;
                lag_idx = (cur_idx >= LAG_DISTANCE) ? cur_idx - LAG_DISTANCE
                                                    : cur_idx + TABLE_LENGTH - LAG_DISTANCE;
                sum   = 64'd2 * lag_table[lag_idx] + 64'd5 * lag_table[cur_idx];
                rem   = sum % LAG_MOD;
                fresh = (rem == 0) ? '0 : VALUE_W'(LAG_MOD - rem);
                lag_table[cur_idx] = fresh;
                table_pos = (cur_idx + 1 >= TABLE_LENGTH) ? 0 : cur_idx + 1;
                // Second stage skips zero
                frac_state = next_fraction(frac_state);
                if (frac_state == '0)
                    frac_state = next_fraction(frac_state);
                pending_pairs.push_back(t_gen_pair'{lagged_value: fresh,
                                                    fraction_numer: frac_state});
            end
            default: ;
        endcase
    endtask

    // Compare one accepted result transaction with the oldest prediction
    task automatic check_result(input logic [VALUE_W-1:0] lagged,
                                input logic [FRAC_W-1:0] frac);
        t_gen_pair want;
        if (pending_pairs.size() == 0) begin
            report_mismatch("unpredicted result, lagged_value", lagged, '0);
        end else begin
            want = pending_pairs.pop_front();
            if (lagged !== want.lagged_value)
                report_mismatch("lagged_value", lagged, want.lagged_value);
            if (frac !== want.fraction_numer)
                report_mismatch("fraction_numer", frac, want.fraction_numer);
        end
    endtask

    // Sample both channels at the clock edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (lag_table[i]) lag_table[i] = '0;
            table_pos  = 0;
            frac_state = '0;
            pending_pairs.delete();
        end else begin
            if (i_out.valid && i_out.ready)
                check_result(i_out.lagged_value, i_out.fraction_numer);
            if (i_in.valid && i_in.ready)
                apply_item(i_in.func, i_in.slot, i_in.value);
        end
        o_mismatches  <= mismatch_count;
        o_outstanding <= pending_pairs.size();
    end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the lagged random generator. Fills the lag table, runs a
// directed set of loads and generates over the corner cases, then a long
// random mix of generate bursts, reseeds, entry loads and table refills
// under three idling phases. Checking lives in lrg_checker.
// ----------------------------------------------------------------------------
module tb_top;
    import lrg_pkg::*;

    localparam int TABLE_LENGTH = 101;
    localparam int RANDOM_ITEMS = 1950;
    localparam int IDLE_LIMIT   = 5000;
    localparam int DRAIN_CYCLES = 8;

    // Function code the block ignores
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    typedef enum int {
        FILL_RANDOM,
        FILL_ZERO,
        FILL_MAX_RESIDUE,
        FILL_WRAPPED
    } t_fill_kind;

    logic i_clk;
    logic i_rst_n;

    lrg_in_if  in_ch ();
    lrg_out_if out_ch ();

    int src_idle_pct;
    int snk_idle_pct;
    int idle_cycles = 0;
    int items_sent  = 0;
    int mismatches;
    int outstanding;

    lagged_random_generator #(
        .TABLE_LENGTH (TABLE_LENGTH)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    lrg_checker #(
        .TABLE_LENGTH (TABLE_LENGTH)
    ) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in          (in_ch),
        .i_out         (out_ch),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    // Clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Receiver stalls at random
    always @(posedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    // Watchdog: ends the run after too many cycles without a transaction
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Drive one item and wait until it is accepted
    task automatic send_item(input logic [FUNC_W-1:0] func,
                             input logic [SLOT_W-1:0] slot,
                             input logic [VALUE_W-1:0] value);
        while ($urandom_range(99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.func  <= func;
        in_ch.slot  <= slot;
        in_ch.value <= value;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
    endtask

    // Load every table entry with one pattern
    task automatic fill_table(input t_fill_kind kind);
        logic [VALUE_W-1:0] v;
        for (int s = 0; s < TABLE_LENGTH; s++) begin
            case (kind)
                FILL_ZERO:        v = '0;
                FILL_MAX_RESIDUE: v = LAG_MOD - 1'b1;
                FILL_WRAPPED:     v = VALUE_W'($urandom_range(2**VALUE_W - 1, LAG_MOD));
                default:          v = VALUE_W'($urandom);
            endcase
            send_item(FUNC_LOAD_ENTRY, SLOT_W'(s), v);
        end
        items_sent += TABLE_LENGTH;
    endtask

    // Generates carry random slot and value bits, which must be ignored
    task automatic gen_burst(input int count);
        repeat (count)
            send_item(FUNC_GENERATE, SLOT_W'($urandom), VALUE_W'($urandom));
        items_sent += count;
    endtask

    initial begin
        logic [FRAC_W-1:0]  inv37;
        logic [FRAC_W-1:0]  zero_step_seed;
        logic [SLOT_W-1:0]  slot;
        logic [VALUE_W-1:0] value;
        int                 pick;
        int                 burst;

        in_ch.valid  = 1'b0;
        in_ch.func   = FUNC_LOAD_ENTRY;
        in_ch.slot   = '0;
        in_ch.value  = '0;
        out_ch.ready = 1'b0;
        i_rst_n      = 1'b0;
        src_idle_pct = 28;
        snk_idle_pct = 66;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Seed whose next step lands on zero: k = -1/37 mod 2^25
        inv37 = FRAC_MULT;
        repeat (5) inv37 = inv37 * (25'd2 - FRAC_MULT * inv37);
        zero_step_seed = -inv37;

        // Directed: full table, then corner cases
        fill_table(FILL_RANDOM);
        send_item(FUNC_LOAD_ENTRY, 7'd0, '1);              // all ones, reduced once
        send_item(FUNC_LOAD_ENTRY, 7'd37, LAG_MOD);        // exactly M becomes zero
        send_item(FUNC_LOAD_ENTRY, 7'd1, LAG_MOD - 1'b1);  // largest residue
        send_item(FUNC_LOAD_ENTRY, 7'd101, '1);            // slot past the table
        send_item(FUNC_LOAD_ENTRY, 7'd127, '0);
        send_item(FUNC_UNUSED, '1, '1);
        send_item(FUNC_LOAD_SEED, '0, '0);                 // zero seed steps to 1
        gen_burst(3);
        send_item(FUNC_LOAD_SEED, '1, {5'b10101, zero_step_seed});
        gen_burst(2);
        send_item(FUNC_LOAD_SEED, '0, '1);                 // high bits dropped
        gen_burst(2);
        fill_table(FILL_MAX_RESIDUE);                       // largest sum
        gen_burst(3);
        fill_table(FILL_ZERO);                              // stays zero
        gen_burst(3);
        fill_table(FILL_WRAPPED);
        gen_burst(110);                                     // position wraps

        // Random mix, idling phases by progress
        while (items_sent < RANDOM_ITEMS) begin
            if (items_sent >= 2 * RANDOM_ITEMS / 3) begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end else if (items_sent >= RANDOM_ITEMS / 3) begin
                src_idle_pct = 66;
                snk_idle_pct = 28;
            end
            pick = $urandom_range(99);
            if (pick < 60) begin
                burst = $urandom_range(150, 1);
                gen_burst(burst);
            end else if (pick < 72) begin
                case ($urandom_range(3))
                    0:       value = {VALUE_W{1'b0}};
                    1:       value = {5'($urandom), zero_step_seed};
                    default: value = VALUE_W'($urandom);
                endcase
                send_item(FUNC_LOAD_SEED, SLOT_W'($urandom), value);
                items_sent++;
            end else if (pick < 88) begin
                slot  = SLOT_W'($urandom);
                value = VALUE_W'($urandom);
                send_item(FUNC_LOAD_ENTRY, slot, value);
                if (slot < TABLE_LENGTH)
                    items_sent++;
            end else if (pick < 92) begin
                send_item(FUNC_UNUSED, SLOT_W'($urandom), VALUE_W'($urandom));
            end else begin
                case ($urandom_range(9))
                    0:       fill_table(FILL_ZERO);
                    1, 2:    fill_table(FILL_MAX_RESIDUE);
                    3, 4:    fill_table(FILL_WRAPPED);
                    default: fill_table(FILL_RANDOM);
                endcase
            end
        end
        in_ch.valid <= 1'b0;

        // Drain, then give stray results a chance to show
        do @(posedge i_clk); while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

[sim.f]
rtl/core/lrg_pkg.sv
rtl/core/lrg_in_if.sv
rtl/core/lrg_out_if.sv
rtl/core/lrg_ram.sv
rtl/core/lrg_table.sv
rtl/core/lrg_lag_mod.sv
rtl/core/lagged_random_generator.sv
tb/sv/lrg_checker.sv
tb/sv/tb_top.sv
